// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/rtsm_pkg.sv -----
// shared types and constants of the task state manager
`default_nettype none
package rtsm_pkg;
    localparam int TASK_SLOTS = 16;
    localparam int MUTEX_NUMBER = 4;
    localparam int MUTEX_QUEUE_DEPTH = 8;
    localparam int SEMAPHORE_NUMBER = 8;
    localparam int SEMAPHORE_QUEUE_DEPTH = 8;
    localparam int TW = $clog2(TASK_SLOTS);
    localparam int MW = (MUTEX_NUMBER > 1) ? $clog2(MUTEX_NUMBER) : 1;
    localparam int SW = (SEMAPHORE_NUMBER > 1) ? $clog2(SEMAPHORE_NUMBER) : 1;
    localparam int MQW = (MUTEX_QUEUE_DEPTH > 1) ? $clog2(MUTEX_QUEUE_DEPTH) : 1;
    localparam int SQW = (SEMAPHORE_QUEUE_DEPTH > 1) ? $clog2(SEMAPHORE_QUEUE_DEPTH) : 1;
    localparam int MLW = $clog2(MUTEX_QUEUE_DEPTH + 1);
    localparam int SLW = $clog2(SEMAPHORE_QUEUE_DEPTH + 1);
    localparam int MQA = $clog2(MUTEX_NUMBER * MUTEX_QUEUE_DEPTH);
    localparam int SQA = $clog2(SEMAPHORE_NUMBER * SEMAPHORE_QUEUE_DEPTH);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [3:0] {
        OP_TICK = 4'd0, OP_SCHED = 4'd1, OP_YIELD = 4'd2, OP_SLEEP = 4'd3,
        OP_LOCK = 4'd4, OP_UNLOCK = 4'd5, OP_WAIT = 4'd6, OP_POST = 4'd7,
        OP_ADD = 4'd8, OP_INIT_MUTEX = 4'd9, OP_INIT_SEM = 4'd10
    } op_t;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BLOCKED = 3'd1;
    localparam logic [2:0] ST_NOT_OWNER = 3'd2;
    localparam logic [2:0] ST_QFULL = 3'd3;
    localparam logic [2:0] ST_NO_READY = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX = 3'd5;
    localparam logic [2:0] ST_TABLE_FULL = 3'd6;

    localparam logic [2:0] TS_INVALID = 3'd0;
    localparam logic [2:0] TS_READY = 3'd2;
    localparam logic [2:0] TS_DELAYED = 3'd3;
    localparam logic [2:0] TS_BLK_MUTEX = 3'd4;
    localparam logic [2:0] TS_BLK_SEM = 3'd5;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;      // capture item, scan start
        logic       scan;      // visit slot scan_idx
        logic       finish;    // apply operation
        logic       shift;     // move one queue entry toward head
        logic       done;      // result registered
    } dp_cmd_t;

    typedef struct packed {
        logic       needs_scan;
        logic       needs_shift;
        logic       scan_last;
        logic       shift_last;
    } dp_stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/rtsm_ram.sv -----
// generic single-port write, registered-read ram
`default_nettype none
module rtsm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/rtsm_ctrl.sv -----
// sequencing state machine of the task state manager
`default_nettype none
module rtsm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire rtsm_pkg::dp_stat_t stat,
    output rtsm_pkg::dp_cmd_t      cmd
);
    import rtsm_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_RDQ, S_SHIFT, S_FINISH} state_t;
    state_t state_reg;
    logic out_valid_reg;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb begin
        cmd = '0;
        cmd.load = in_valid && in_ready;
        cmd.scan = (state_reg == S_SCAN);
        cmd.shift = (state_reg == S_SHIFT);
        cmd.finish = (state_reg == S_FINISH);
        cmd.done = (state_reg == S_FINISH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready) begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (stat.needs_scan) begin
                        state_reg <= S_SCAN;
                    end else if (stat.needs_shift) begin
                        state_reg <= S_RDQ;
                    end else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_SCAN: begin
                    if (stat.scan_last) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_RDQ: state_reg <= S_SHIFT;
                S_SHIFT: begin
                    if (stat.shift_last) begin
                        state_reg <= S_FINISH;
                    end else begin
                        state_reg <= S_RDQ;
                    end
                end
                S_FINISH: begin
                    state_reg <= S_IDLE;
                    out_valid_reg <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/rtsm_dp.sv -----
// task table, object state and wait queues
`default_nettype none
module rtsm_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rtsm_pkg::dp_cmd_t cmd,
    output rtsm_pkg::dp_stat_t     stat,
    input  wire logic [3:0]        in_op,
    input  wire logic [2:0]        in_obj,
    input  wire logic [31:0]       in_arg,
    output logic [2:0]             res_status,
    output logic                   res_switch,
    output logic [3:0]             res_task,
    output logic                   res_woken_valid,
    output logic [3:0]             res_woken_task
);
    import rtsm_pkg::*;

    logic [3:0]  op_reg;
    logic [2:0]  obj_reg;
    logic [31:0] arg_reg;
    logic [2:0]  tstate_reg [TASK_SLOTS];
    logic [31:0] ticks_reg [TASK_SLOTS];
    logic [TW-1:0] rr_reg, cur_reg;
    logic [CW-1:0] total_reg;
    logic [MUTEX_NUMBER-1:0] mlock_reg;
    logic [TW-1:0] mowner_reg [MUTEX_NUMBER];
    logic [MLW-1:0] mlen_reg [MUTEX_NUMBER];
    logic [7:0] scount_reg [SEMAPHORE_NUMBER];
    logic [SLW-1:0] slen_reg [SEMAPHORE_NUMBER];
    logic [TW-1:0] scan_idx_reg;
    logic [TW:0]   scan_cnt_reg;
    logic          found_reg;
    logic [TW-1:0] found_idx_reg;
    logic [6:0]    shift_pos_reg;
    logic          head_valid_reg;
    logic [TW-1:0] head_reg;
    logic          rd_phase_reg;
    logic [2:0]    status_reg;
    logic          sw_reg, wv_reg;
    logic [3:0]    tix_reg, wt_reg;

    logic is_mutex_op, is_sem_op, bad_obj, mobj_ok, sobj_ok;
    logic [MW-1:0] mi;
    logic [SW-1:0] si;
    logic unlock_pop, post_pop;
    logic [6:0] qlen;

    assign mi = obj_reg[MW-1:0];
    assign si = obj_reg[SW-1:0];
    assign mobj_ok = 32'(obj_reg) < MUTEX_NUMBER;
    assign sobj_ok = 32'(obj_reg) < SEMAPHORE_NUMBER;
    assign is_mutex_op = (op_reg == OP_LOCK) || (op_reg == OP_UNLOCK) ||
                         (op_reg == OP_INIT_MUTEX);
    assign is_sem_op = (op_reg == OP_WAIT) || (op_reg == OP_POST) ||
                       (op_reg == OP_INIT_SEM);
    assign bad_obj = (is_mutex_op && !mobj_ok) || (is_sem_op && !sobj_ok);
    assign unlock_pop = (op_reg == OP_UNLOCK) && mobj_ok && mlock_reg[mi] &&
                        (mowner_reg[mi] == cur_reg) && (mlen_reg[mi] != '0);
    assign post_pop = (op_reg == OP_POST) && sobj_ok && (slen_reg[si] != '0);
    assign qlen = unlock_pop ? 7'(mlen_reg[mi]) : 7'(slen_reg[si]);

    assign stat.needs_scan = (op_reg == OP_TICK) || (op_reg == OP_SCHED) ||
                             ((op_reg == OP_ADD) && (32'(total_reg) < TASK_SLOTS));
    assign stat.needs_shift = unlock_pop || post_pop;
    assign stat.scan_last = (32'(scan_cnt_reg) == TASK_SLOTS - 1);
    assign stat.shift_last = rd_phase_reg && (shift_pos_reg + 7'd1 >= qlen);

    // wait queues in ram: read address walks shift_pos+1, write at shift_pos
    logic mq_we, sq_we;
    logic [MQA-1:0] mq_waddr, mq_raddr;
    logic [SQA-1:0] sq_waddr, sq_raddr;
    logic [TW-1:0] mq_wdata, sq_wdata, mq_rdata, sq_rdata;
    logic [6:0] rd_pos;
    logic [6:0] rd_pos_m, rd_pos_s;
    assign rd_pos = head_valid_reg ? shift_pos_reg + 7'd1 : 7'd0;
    assign rd_pos_m = (rd_pos >= 7'(MUTEX_QUEUE_DEPTH)) ? 7'd0 : rd_pos;
    assign rd_pos_s = (rd_pos >= 7'(SEMAPHORE_QUEUE_DEPTH)) ? 7'd0 : rd_pos;
    assign mq_raddr = MQA'(32'(mi) * MUTEX_QUEUE_DEPTH + 32'(rd_pos_m));
    assign sq_raddr = SQA'(32'(si) * SEMAPHORE_QUEUE_DEPTH + 32'(rd_pos_s));

    always_comb begin
        mq_we = 1'b0;
        sq_we = 1'b0;
        mq_waddr = MQA'(32'(mi) * MUTEX_QUEUE_DEPTH + 32'(shift_pos_reg));
        sq_waddr = SQA'(32'(si) * SEMAPHORE_QUEUE_DEPTH + 32'(shift_pos_reg));
        mq_wdata = mq_rdata;
        sq_wdata = sq_rdata;
        if (cmd.shift && head_valid_reg && rd_phase_reg) begin
            mq_we = unlock_pop;
            sq_we = post_pop;
        end
        if (cmd.finish) begin
            mq_waddr = MQA'(32'(mi) * MUTEX_QUEUE_DEPTH + 32'(mlen_reg[mi]));
            sq_waddr = SQA'(32'(si) * SEMAPHORE_QUEUE_DEPTH + 32'(slen_reg[si]));
            mq_wdata = cur_reg;
            sq_wdata = cur_reg;
            mq_we = (op_reg == OP_LOCK) && mobj_ok && mlock_reg[mi] &&
                    (32'(mlen_reg[mi]) < MUTEX_QUEUE_DEPTH);
            sq_we = (op_reg == OP_WAIT) && sobj_ok && (scount_reg[si] == 8'd0) &&
                    (32'(slen_reg[si]) < SEMAPHORE_QUEUE_DEPTH);
        end
    end

    rtsm_ram #(.WIDTH(TW), .DEPTH(MUTEX_NUMBER * MUTEX_QUEUE_DEPTH)) u_mq (
        .aclk(aclk), .we(mq_we), .waddr(mq_waddr), .wdata(mq_wdata),
        .raddr(mq_raddr), .rdata(mq_rdata)
    );
    rtsm_ram #(.WIDTH(TW), .DEPTH(SEMAPHORE_NUMBER * SEMAPHORE_QUEUE_DEPTH)) u_sq (
        .aclk(aclk), .we(sq_we), .waddr(sq_waddr), .wdata(sq_wdata),
        .raddr(sq_raddr), .rdata(sq_rdata)
    );

    logic [TW-1:0] qrd;
    assign qrd = unlock_pop ? mq_rdata : sq_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASK_SLOTS; i++) tstate_reg[i] <= TS_INVALID;
            rr_reg <= TW'(TASK_SLOTS - 1);
            cur_reg <= '0;
            total_reg <= '0;
            mlock_reg <= '0;
            for (int i = 0; i < MUTEX_NUMBER; i++) begin
                mowner_reg[i] <= '0;
                mlen_reg[i] <= '0;
            end
            for (int i = 0; i < SEMAPHORE_NUMBER; i++) begin
                scount_reg[i] <= '0;
                slen_reg[i] <= '0;
            end
            found_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                op_reg <= in_op;
                obj_reg <= in_obj;
                arg_reg <= in_arg;
                found_reg <= 1'b0;
                scan_cnt_reg <= '0;
                shift_pos_reg <= '0;
                head_valid_reg <= 1'b0;
                rd_phase_reg <= 1'b0;
                scan_idx_reg <= (in_op == OP_SCHED) ? rr_reg + TW'(1) : '0;
            end
            if (cmd.scan) begin
                scan_cnt_reg <= scan_cnt_reg + (TW+1)'(1);
                scan_idx_reg <= scan_idx_reg + TW'(1);
                if (op_reg == OP_TICK) begin
                    if (tstate_reg[scan_idx_reg] == TS_DELAYED) begin
                        if (ticks_reg[scan_idx_reg] == 32'd0) begin
                            tstate_reg[scan_idx_reg] <= TS_READY;
                        end else begin
                            ticks_reg[scan_idx_reg] <= ticks_reg[scan_idx_reg] - 32'd1;
                        end
                    end
                end else if (!found_reg) begin
                    if ((op_reg == OP_SCHED && tstate_reg[scan_idx_reg] == TS_READY) ||
                        (op_reg == OP_ADD && tstate_reg[scan_idx_reg] == TS_INVALID)) begin
                        found_reg <= 1'b1;
                        found_idx_reg <= scan_idx_reg;
                    end
                end
            end
            if (cmd.shift) begin
                rd_phase_reg <= !rd_phase_reg;
                if (rd_phase_reg) begin
                    if (!head_valid_reg) begin
                        head_valid_reg <= 1'b1;
                        head_reg <= qrd;
                    end else begin
                        shift_pos_reg <= shift_pos_reg + 7'd1;
                    end
                end
            end
            if (cmd.finish) begin
                status_reg <= ST_OK;
                sw_reg <= 1'b0;
                wv_reg <= 1'b0;
                wt_reg <= '0;
                tix_reg <= 4'(cur_reg);
                if (bad_obj) begin
                    status_reg <= ST_BAD_INDEX;
                end else begin
                    unique case (op_reg)
                        OP_TICK, OP_YIELD: sw_reg <= 1'b1;
                        OP_SCHED: begin
                            if (found_reg) begin
                                rr_reg <= found_idx_reg;
                                cur_reg <= found_idx_reg;
                                tix_reg <= 4'(found_idx_reg);
                            end else begin
                                status_reg <= ST_NO_READY;
                            end
                        end
                        OP_SLEEP: begin
                            ticks_reg[cur_reg] <= arg_reg;
                            tstate_reg[cur_reg] <= TS_DELAYED;
                            sw_reg <= 1'b1;
                        end
                        OP_LOCK: begin
                            if (!mlock_reg[mi]) begin
                                mlock_reg[mi] <= 1'b1;
                                mowner_reg[mi] <= cur_reg;
                            end else if (32'(mlen_reg[mi]) >= MUTEX_QUEUE_DEPTH) begin
                                status_reg <= ST_QFULL;
                            end else begin
                                mlen_reg[mi] <= mlen_reg[mi] + MLW'(1);
                                tstate_reg[cur_reg] <= TS_BLK_MUTEX;
                                status_reg <= ST_BLOCKED;
                                sw_reg <= 1'b1;
                            end
                        end
                        OP_UNLOCK: begin
                            if (!mlock_reg[mi] || mowner_reg[mi] != cur_reg) begin
                                status_reg <= ST_NOT_OWNER;
                            end else if (unlock_pop) begin
                                mlen_reg[mi] <= mlen_reg[mi] - MLW'(1);
                                tstate_reg[head_reg] <= TS_READY;
                                mowner_reg[mi] <= head_reg;
                                wv_reg <= 1'b1;
                                wt_reg <= 4'(head_reg);
                            end else begin
                                mlock_reg[mi] <= 1'b0;
                            end
                        end
                        OP_WAIT: begin
                            if (scount_reg[si] != 8'd0) begin
                                scount_reg[si] <= scount_reg[si] - 8'd1;
                            end else if (32'(slen_reg[si]) >= SEMAPHORE_QUEUE_DEPTH) begin
                                status_reg <= ST_QFULL;
                            end else begin
                                slen_reg[si] <= slen_reg[si] + SLW'(1);
                                tstate_reg[cur_reg] <= TS_BLK_SEM;
                                status_reg <= ST_BLOCKED;
                                sw_reg <= 1'b1;
                            end
                        end
                        OP_POST: begin
                            if (post_pop) begin
                                slen_reg[si] <= slen_reg[si] - SLW'(1);
                                tstate_reg[head_reg] <= TS_READY;
                                wv_reg <= 1'b1;
                                wt_reg <= 4'(head_reg);
                            end else if (scount_reg[si] != COUNT_MAX) begin
                                scount_reg[si] <= scount_reg[si] + 8'd1;
                            end
                        end
                        OP_ADD: begin
                            if (found_reg) begin
                                tstate_reg[found_idx_reg] <= TS_READY;
                                total_reg <= total_reg + CW'(1);
                                tix_reg <= 4'(found_idx_reg);
                            end else begin
                                status_reg <= ST_TABLE_FULL;
                            end
                        end
                        OP_INIT_MUTEX: begin
                            mlock_reg[mi] <= 1'b0;
                            mowner_reg[mi] <= '0;
                        end
                        OP_INIT_SEM: begin
                            scount_reg[si] <= (arg_reg > 32'(COUNT_MAX)) ? COUNT_MAX :
                                              arg_reg[7:0];
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    assign res_status = status_reg;
    assign res_switch = sw_reg;
    assign res_task = tix_reg;
    assign res_woken_valid = wv_reg;
    assign res_woken_task = wt_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/rtos_task_state_manager.sv -----
// top level of the task state manager
// channel | dir | tdata fields (low bit up)                         | tuser
// s_      | in  | operation[3:0] object_index[6:4] argument[38:7]   | -
// m_      | out | status[2:0] switch[3] task[7:4] woken_v[8] woken[12:9] | -
// one operation at a time; tick/schedule scan all 16 task slots, add too while the table has room
// unlock/post with waiters take the head waiter and walk the wait queue,
// reading each entry from ram and writing it one place toward the head
// reset clears task table, mutexes and semaphores
// a held result stalls the next input transfer until taken
`default_nettype none
module rtos_task_state_manager (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // operation, object_index, argument_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // status, switch_request, task_index, woken_valid, woken_task
);
    import rtsm_pkg::*;
    `include "assert_macros.svh"
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic [2:0] st;
    logic sw, wv;
    logic [3:0] tix, wt;

    rtsm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .stat(stat), .cmd(cmd)
    );
    rtsm_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_op(s_tdata[3:0]), .in_obj(s_tdata[6:4]), .in_arg(s_tdata[38:7]),
        .res_status(st), .res_switch(sw), .res_task(tix),
        .res_woken_valid(wv), .res_woken_task(wt)
    );
    assign m_tdata = {3'b000, wt, wv, tix, sw, st};

    `ASSERT_IMPLIES(a_no_accept_busy, aclk, aresetn, cmd.scan, !s_tready)
    `ASSERT_NEXT(a_done_valid, aclk, aresetn, cmd.done, m_tvalid)
    `ASSERT_IMPLIES(a_woken_ok, aclk, aresetn, m_tvalid && m_tdata[8], m_tdata[2:0] == ST_OK)
endmodule
`default_nettype wire
